/* rtl/accel_decimate_quantize_framer_top_assert.svh */
// Assertion macros shared by the decimate/quantize/framer RTL.
// Included by each module that carries concurrent checks; no other dependencies.
`ifndef ACCEL_DECIMATE_QUANTIZE_FRAMER_TOP_ASSERT_SVH
`define ACCEL_DECIMATE_QUANTIZE_FRAMER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define DQF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
`define DQF_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("check failed");
`else
`define DQF_ASSERT(lbl, clk, rst, prop)
`define DQF_NEVER(lbl, clk, rst, cond)
`endif
`endif

/* rtl/dqf_pkg.sv */
// Types, constants and the FIR tap function for the decimate/quantize/framer.
// No dependencies.
package dqf_pkg;
   localparam int ACC_BITS     = 18;
   localparam int SAMPLE_BITS  = 16;
   localparam int IN_BITS      = 16;
   localparam int AXES         = 3;
   localparam int PHASE_BITS   = 3;
   localparam int FIFO_DEPTH   = 4;
   localparam int MARKER_COUNT = 3;

   localparam logic [PHASE_BITS-1:0] LAST_PHASE = 3'd4;

   localparam logic [1:0] CSR_QUANT_SHIFT = 2'd0;
   localparam logic [1:0] CSR_FRAME_LEN   = 2'd1;
   localparam logic [1:0] CSR_MARKER      = 2'd2;

   localparam logic [3:0]        QSHIFT_RESET = 4'd4;
   localparam logic [5:0]        FRAME_RESET  = 6'd20;
   localparam logic signed [7:0] MARKER_RESET = -8'sd128;

   typedef struct packed {
      logic                  mark;
      logic [AXES-1:0][7:0]  bytes;
   } entry_type;

   function automatic logic signed [ACC_BITS-1:0] tap_term(
      input logic signed [ACC_BITS-1:0] s,
      input logic [PHASE_BITS-1:0]      phase
   );
      logic signed [ACC_BITS-1:0] t;
      case (phase)
         3'd1, 3'd3: begin
            t = (s >>> 2) - (s >>> 6);
         end
         3'd2: begin
            t = (s >>> 1) - (s >>> 5);
         end
         default: begin
            t = s >>> 5;
         end
      endcase
      return t;
   endfunction
endpackage

/* rtl/dqf_front.sv */
// Front end: accepts sample requests, runs the three FIR accumulators and
// quantizes each decimated sample into a queue entry. Uses dqf_pkg.
`include "accel_decimate_quantize_framer_top_assert.svh"
module dqf_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dqf_pkg::AXES*dqf_pkg::IN_BITS-1:0] req_tdata,
   input  logic [3:0]                          quant_shift,
   input  logic [5:0]                          samples_per_frame,
   input  logic                                fifo_full,
   output logic                                push,
   output dqf_pkg::entry_type                  push_entry
);
   import dqf_pkg::*;

   logic [PHASE_BITS-1:0]             phase_ff, phase_in;
   logic signed [ACC_BITS-1:0]        acc_ff [AXES];
   logic signed [ACC_BITS-1:0]        acc_in [AXES];
   logic signed [ACC_BITS-1:0]        sum    [AXES];
   logic signed [ACC_BITS-1:0]        shifted[AXES];
   logic [5:0]                        fsc_ff, fsc_in, fsc_next;
   logic                              accept;
   logic                              final_phase;

   assign final_phase = (phase_ff == LAST_PHASE);
   assign req_tready  = !final_phase || !fifo_full;
   assign accept      = req_tvalid && req_tready;
   assign fsc_next    = fsc_ff + 6'd1;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         sum[a] = tap_term(
            ACC_BITS'($signed(req_tdata[a*IN_BITS +: SAMPLE_BITS])), phase_ff);
         if (phase_ff != '0) begin
            sum[a] = acc_ff[a] + sum[a];
         end
         shifted[a] = sum[a] >>> quant_shift;
         acc_in[a]  = accept ? sum[a] : acc_ff[a];
      end
   end

   always_comb begin
      phase_in = phase_ff;
      fsc_in   = fsc_ff;
      push     = 1'b0;
      push_entry.mark = (fsc_next >= samples_per_frame);
      for (int a = 0; a < AXES; a++) begin
         push_entry.bytes[a] = shifted[a][7:0];
      end
      if (accept) begin
         if (final_phase) begin
            phase_in = '0;
            push     = 1'b1;
            fsc_in   = push_entry.mark ? 6'd0 : fsc_next;
         end else begin
            phase_in = phase_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         fsc_ff   <= '0;
         for (int a = 0; a < AXES; a++) begin
            acc_ff[a] <= '0;
         end
      end else begin
         phase_ff <= phase_in;
         fsc_ff   <= fsc_in;
         for (int a = 0; a < AXES; a++) begin
            acc_ff[a] <= acc_in[a];
         end
      end
   end

   `DQF_ASSERT(a_phase_range, clock, reset, phase_ff <= LAST_PHASE)
   `DQF_NEVER(a_push_full, clock, reset, push && fifo_full)
   `DQF_ASSERT(a_phase_wrap, clock, reset, (accept && final_phase) |=> phase_ff == '0)
endmodule

/* rtl/dqf_fifo.sv */
// Short queue of decimated sample entries between front and back end.
// Uses dqf_pkg for the entry type and depth.
`include "accel_decimate_quantize_framer_top_assert.svh"
module dqf_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dqf_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output dqf_pkg::entry_type pop_entry
);
   import dqf_pkg::*;

   localparam int PW = $clog2(FIFO_DEPTH);

   entry_type     mem [FIFO_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]   cnt_ff, cnt_in;

   assign full      = (cnt_ff == (PW+1)'(FIFO_DEPTH));
   assign valid     = (cnt_ff != '0);
   assign pop_entry = mem[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   `DQF_NEVER(a_pop_empty, clock, reset, pop && !valid)
   `DQF_ASSERT(a_cnt_range, clock, reset, cnt_ff <= (PW+1)'(FIFO_DEPTH))
endmodule

/* rtl/dqf_back.sv */
// Back end: serializes queue entries into axis and marker bytes behind an
// output register. Uses dqf_pkg.
`include "accel_decimate_quantize_framer_top_assert.svh"
module dqf_back #(
   parameter int MARKER_COUNT = dqf_pkg::MARKER_COUNT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               fifo_valid,
   input  dqf_pkg::entry_type fifo_entry,
   output logic               pop,
   input  logic signed [7:0]  marker_value,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tuser,
   output logic               rsp_tlast
);
   import dqf_pkg::*;

   localparam int NB = AXES + MARKER_COUNT;
   localparam int IW = $clog2(NB);

   entry_type     cur_ff, cur_in;
   logic          busy_ff, busy_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          valid_ff, valid_in;
   logic [7:0]    data_ff, data_in;
   logic          user_ff, user_in;
   logic          last_ff, last_in;
   logic          out_free, emit, done, last_byte, is_axis;

   assign out_free  = !valid_ff || rsp_tready;
   assign emit      = busy_ff && out_free;
   assign is_axis   = (idx_ff < IW'(AXES));
   assign last_byte = cur_ff.mark ? (idx_ff == IW'(NB-1)) : (idx_ff == IW'(AXES-1));
   assign done      = emit && last_byte;
   assign pop       = fifo_valid && (!busy_ff || done);

   always_comb begin
      cur_in   = pop ? fifo_entry : cur_ff;
      busy_in  = pop ? 1'b1 : (done ? 1'b0 : busy_ff);
      idx_in   = pop ? '0 : (emit ? idx_ff + 1'b1 : idx_ff);
      valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
      data_in  = data_ff;
      user_in  = user_ff;
      last_in  = last_ff;
      if (emit) begin
         data_in = is_axis ? cur_ff.bytes[idx_ff[1:0]] : marker_value;
         user_in = !is_axis;
         last_in = last_byte;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

   `DQF_ASSERT(a_idx_range, clock, reset, busy_ff |-> idx_ff <= IW'(NB-1))
   `DQF_ASSERT(a_hold, clock, reset, (valid_ff && !rsp_tready) |=> $stable(data_ff))
endmodule

/* rtl/accel_decimate_quantize_framer_top.sv */
// Top level of the accelerometer decimate/quantize/framer block.
// Depends on dqf_pkg, dqf_front, dqf_fifo and dqf_back.
//
// Requests carry one x/y/z sample (16-bit signed each) on req_tdata. Every
// fifth request ends a group: each axis FIR sum is shifted right by
// quant_shift and its low byte emitted, in x, y, z order, on rsp_tdata.
// After samples_per_frame decimated samples, MARKER_COUNT marker bytes
// follow with rsp_tuser high. rsp_tlast marks the last byte of a group.
// Requests are taken one per cycle; the group-ending request is held off
// only while the four-entry queue between filter and serializer is full.
// A group's first byte passes the queue, entry and output registers; the
// serializer sends one byte per cycle while the output is free, so a group
// is 3 or 3 + MARKER_COUNT bytes long. A stalled rsp_tready holds the
// output register and backs up the queue, then the request side.
// csr_we writes register csr_addr: 0 quant_shift, 1 samples_per_frame,
// 2 marker_value; other indexes are ignored. Reset (synchronous) clears
// filter phase, sums, frame count and queue and restores register defaults.
module accel_decimate_quantize_framer_top #(
   parameter int MARKER_COUNT = dqf_pkg::MARKER_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,    // x [15:0], y [31:16], z [47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // out_byte [7:0]
   output logic        rsp_tuser,    // is_marker
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);
   import dqf_pkg::*;

   logic [3:0]        qshift_ff;
   logic [5:0]        frame_ff;
   logic signed [7:0] marker_ff;
   logic              fifo_full, fifo_valid, push, pop;
   entry_type         push_entry, pop_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         qshift_ff <= QSHIFT_RESET;
         frame_ff  <= FRAME_RESET;
         marker_ff <= MARKER_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_QUANT_SHIFT: qshift_ff <= csr_wdata[3:0];
            CSR_FRAME_LEN:   frame_ff  <= csr_wdata[5:0];
            CSR_MARKER:      marker_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   dqf_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .quant_shift       (qshift_ff),
      .samples_per_frame (frame_ff),
      .fifo_full         (fifo_full),
      .push              (push),
      .push_entry        (push_entry)
   );

   dqf_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (fifo_full),
      .pop        (pop),
      .valid      (fifo_valid),
      .pop_entry  (pop_entry)
   );

   dqf_back #(
      .MARKER_COUNT (MARKER_COUNT)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .fifo_valid   (fifo_valid),
      .fifo_entry   (pop_entry),
      .pop          (pop),
      .marker_value (marker_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );
endmodule
